@@ hw/rtl/pcbst_pkg.sv @@
// Shared constants, types and pin tables for the power-cycle blank-screen tester.
package pcbst_pkg;

    localparam int MAX_REGIONS         = 8;
    localparam int NUM_REGIONS_DEF     = 8;
    localparam int MEAN_FRAC_BITS_DEF  = 4;

    localparam int MEAN_W   = 12;
    localparam int THR_W    = 8;
    localparam int MASK_W   = 8;
    localparam int DUR_W    = 16;
    localparam int POS_W    = 18;
    localparam int PCOUNT_W = 17;
    localparam int WIN_W    = 16;
    localparam int TEST_W   = 32;
    localparam int PHASE_W  = 4;
    localparam int PIN_W    = 8;
    localparam int BLANK_W  = 4;

    localparam int IN_TDATA_W  = 112;
    localparam int IN_USED_W   = 2 + MASK_W + MAX_REGIONS * MEAN_W;
    localparam int OUT_TDATA_W = 128;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMPARE_HIGH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_POLARITY      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_POWER_OFF     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA_DELAY  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_DELAY   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_TICKS   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP_ON_BLANK = 3'd7;

    localparam logic [PHASE_W-1:0] PH_OFF        = 4'd0;
    localparam logic [PHASE_W-1:0] PH_OFF_WAIT   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_HOST_ON    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_CAM_WAIT   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_CAM_ON     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CHECK_WAIT = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CHECKING   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DONE       = 4'd7;
    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd8;

    // Fixed bytes of the GPIO command frame folded into one XOR term.
    localparam logic [PIN_W-1:0] FRAME_HDR_XOR = 8'h03 ^ 8'h02 ^ 8'h02 ^ 8'h28;

    typedef logic [MAX_REGIONS-1:0][MEAN_W-1:0] mean_array_t;

    function automatic logic [PIN_W-1:0] off_pins(input logic [1:0] pol);
        logic [PIN_W-1:0] v;
        case (pol)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h0F;
            2'd2:    v = 8'hF0;
            default: v = 8'hFF;
        endcase
        return v;
    endfunction

    function automatic logic [PIN_W-1:0] host_pins(input logic [1:0] pol);
        logic [PIN_W-1:0] v;
        case (pol)
            2'd0:    v = 8'hF0;
            2'd1:    v = 8'hFF;
            2'd2:    v = 8'h00;
            default: v = 8'h0F;
        endcase
        return v;
    endfunction

    function automatic logic [PIN_W-1:0] cam_pins(input logic [1:0] pol);
        logic [PIN_W-1:0] v;
        case (pol)
            2'd0:    v = 8'hFF;
            2'd1:    v = 8'hF0;
            2'd2:    v = 8'h0F;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/pcbst_region_count.sv @@
// Counts the masked regions whose mean brightness is past the threshold.
module pcbst_region_count #(
    parameter int NUM_REGIONS    = pcbst_pkg::NUM_REGIONS_DEF,
    parameter int MEAN_FRAC_BITS = pcbst_pkg::MEAN_FRAC_BITS_DEF
) (
    input  logic [pcbst_pkg::MASK_W-1:0]  region_mask,
    input  pcbst_pkg::mean_array_t        means,
    input  logic [pcbst_pkg::THR_W-1:0]   threshold,
    input  logic                          compare_high,
    output logic [pcbst_pkg::BLANK_W-1:0] blank_count
);

    localparam int LIM_W = pcbst_pkg::THR_W + MEAN_FRAC_BITS;
    localparam int CMP_W = (LIM_W > pcbst_pkg::MEAN_W) ? LIM_W : pcbst_pkg::MEAN_W;

    logic [CMP_W-1:0] limit;

    assign limit = CMP_W'(threshold) << MEAN_FRAC_BITS;

    always_comb
    begin
        logic [CMP_W-1:0] m;
        logic             hit;
        blank_count = '0;
        for (int i = 0; i < NUM_REGIONS && i < pcbst_pkg::MAX_REGIONS; i++)
        begin
            m   = CMP_W'(means[i]);
            hit = compare_high ? (m >= limit) : (m <= limit);
            if (region_mask[i] && hit)
            begin
                blank_count = blank_count + pcbst_pkg::BLANK_W'(1);
            end
        end
    end

endmodule

@@ hw/rtl/power_cycle_blank_screen_tester.sv @@
// Top level of the power-cycle blank-screen tester: tick sequencer and result stream.
//
// Each slave transfer is one time tick and yields exactly one master transfer. A tick is
// captured in an input register, then one pass of logic steps the power-cycle position
// (off, off wait, host on, camera wait, camera on, check wait, checking, done), picks the
// GPIO pin byte from the polarity tables, counts blank regions and updates the window,
// test and failure counters, and loads the result register. One tick is taken every
// cycle as long as the result side keeps up, because the input register reloads in the
// same cycle that the result register does. While a result waits, the input register
// holds one more tick and then the slave side stalls until the result transfer goes out.
// Phase, phase count and blank region count hold their last value on ticks that
// do not set them. Restart clears the position and counters (also lifting a stop) but
// keeps the held outputs. Write configuration only while no tick is in flight.
module power_cycle_blank_screen_tester #(
    parameter int NUM_REGIONS    = pcbst_pkg::NUM_REGIONS_DEF,
    parameter int MEAN_FRAC_BITS = pcbst_pkg::MEAN_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Slave tick stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // run_enable[0], restart[1], region_mask[9:2], mean_0[21:10] .. mean_7[105:94], zero pad
    input  logic [pcbst_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Master result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // phase[3:0], phase_count[20:4], send_frame[21], pin_value[29:22],
    // frame_checksum[37:30], blank_regions[41:38], blank_windows[57:42],
    // test_count[89:58], fail_count[121:90], cycle_failed[122], stopped[123], zero pad
    output logic [pcbst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [pcbst_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pcbst_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int POS_W    = pcbst_pkg::POS_W;
    localparam int PCOUNT_W = pcbst_pkg::PCOUNT_W;
    localparam int WIN_W    = pcbst_pkg::WIN_W;
    localparam int TEST_W   = pcbst_pkg::TEST_W;
    localparam int PHASE_W  = pcbst_pkg::PHASE_W;
    localparam int PIN_W    = pcbst_pkg::PIN_W;
    localparam int BLANK_W  = pcbst_pkg::BLANK_W;
    localparam int DUR_W    = pcbst_pkg::DUR_W;
    localparam int MEAN_W   = pcbst_pkg::MEAN_W;
    localparam int MASK_W   = pcbst_pkg::MASK_W;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [pcbst_pkg::THR_W-1:0] threshold_reg;
    logic                        compare_high_reg;
    logic [1:0]                  polarity_reg;
    logic [DUR_W-1:0]            power_off_reg;
    logic [DUR_W-1:0]            camera_delay_reg;
    logic [DUR_W-1:0]            check_delay_reg;
    logic [DUR_W-1:0]            check_ticks_reg;
    logic                        stop_on_blank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= '0;
            compare_high_reg  <= 1'b0;
            polarity_reg      <= '0;
            power_off_reg     <= '0;
            camera_delay_reg  <= '0;
            check_delay_reg   <= '0;
            check_ticks_reg   <= '0;
            stop_on_blank_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pcbst_pkg::CFG_THRESHOLD:     threshold_reg     <= cfg_wdata[pcbst_pkg::THR_W-1:0];
                pcbst_pkg::CFG_COMPARE_HIGH:  compare_high_reg  <= cfg_wdata[0];
                pcbst_pkg::CFG_POLARITY:      polarity_reg      <= cfg_wdata[1:0];
                pcbst_pkg::CFG_POWER_OFF:     power_off_reg     <= cfg_wdata;
                pcbst_pkg::CFG_CAMERA_DELAY:  camera_delay_reg  <= cfg_wdata;
                pcbst_pkg::CFG_CHECK_DELAY:   check_delay_reg   <= cfg_wdata;
                pcbst_pkg::CFG_CHECK_TICKS:   check_ticks_reg   <= cfg_wdata;
                pcbst_pkg::CFG_STOP_ON_BLANK: stop_on_blank_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input register and handshake
    // ---------------------------------------------------------------------
    logic                           in_valid_reg;
    logic [pcbst_pkg::IN_USED_W-1:0] in_data_reg;
    logic                           out_valid_reg;
    logic                           adv;

    // Step the stored tick when the result register is free or being drained.
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata[pcbst_pkg::IN_USED_W-1:0];
        end
    end

    // Unpack the stored tick
    logic                  run_en;
    logic                  restart;
    logic [MASK_W-1:0]     region_mask;
    pcbst_pkg::mean_array_t means;

    assign run_en      = in_data_reg[0];
    assign restart     = in_data_reg[1];
    assign region_mask = in_data_reg[2 +: MASK_W];

    always_comb
    begin
        for (int i = 0; i < pcbst_pkg::MAX_REGIONS; i++)
        begin
            means[i] = in_data_reg[2 + MASK_W + i * MEAN_W +: MEAN_W];
        end
    end

    logic [BLANK_W-1:0] blank_count;

    pcbst_region_count #(
        .NUM_REGIONS    (NUM_REGIONS),
        .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
    ) u_region_count (
        .region_mask  (region_mask),
        .means        (means),
        .threshold    (threshold_reg),
        .compare_high (compare_high_reg),
        .blank_count  (blank_count)
    );

    // ---------------------------------------------------------------------
    // Sequencer state. The result registers of phase, phase count, blank
    // regions and the three counters double as the held state.
    // pos_reg is the index of the next tick in the cycle (zero means the
    // next tick is the power-off tick).
    // ---------------------------------------------------------------------
    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [PHASE_W-1:0]  phase_reg,   phase_next;
    logic [PCOUNT_W-1:0] pcount_reg,  pcount_next;
    logic                send_reg,    send_next;
    logic [PIN_W-1:0]    pin_reg,     pin_next;
    logic [PIN_W-1:0]    cksum_reg,   cksum_next;
    logic [BLANK_W-1:0]  regions_reg, regions_next;
    logic [WIN_W-1:0]    win_reg,     win_next;
    logic [TEST_W-1:0]   done_reg,    done_next;
    logic [TEST_W-1:0]   fail_reg,    fail_next;
    logic                failed_reg,  failed_next;
    logic                stopped_reg, stopped_next;

    logic [POS_W-1:0]  t_p, t_pc, t_pd, t_pk;
    logic [WIN_W-1:0]  win_base;
    logic [TEST_W-1:0] done_base, fail_base;
    logic [POS_W-1:0]  pos_base;
    logic              frozen;

    // Phase boundaries as tick indexes within the cycle
    assign t_p  = POS_W'(power_off_reg);
    assign t_pc = t_p + POS_W'(camera_delay_reg);
    assign t_pd = t_p + POS_W'(check_delay_reg);
    assign t_pk = t_pd + POS_W'(check_ticks_reg);

    // Restart clears position and counters before the tick is looked at
    assign pos_base  = restart ? '0 : pos_reg;
    assign win_base  = restart ? '0 : win_reg;
    assign done_base = restart ? '0 : done_reg;
    assign fail_base = restart ? '0 : fail_reg;
    assign frozen    = stop_on_blank_reg && (fail_base != '0);

    always_comb
    begin
        logic [POS_W-1:0] t;
        logic [PIN_W-1:0] pin;
        t            = pos_base;
        pin          = '0;
        pos_next     = pos_base;
        phase_next   = phase_reg;
        pcount_next  = pcount_reg;
        send_next    = 1'b0;
        regions_next = regions_reg;
        win_next     = win_base;
        done_next    = done_base;
        fail_next    = fail_base;
        failed_next  = 1'b0;
        stopped_next = frozen;

        if (!frozen && run_en)
        begin
            pos_next = t + POS_W'(1);

            // Phase tests in order so a zero duration skips its wait phase
            if (t == '0)
            begin
                phase_next = pcbst_pkg::PH_OFF;
            end
            else if (t < t_p)
            begin
                phase_next  = pcbst_pkg::PH_OFF_WAIT;
                pcount_next = PCOUNT_W'(t);
            end
            else if (t == t_p)
            begin
                phase_next = pcbst_pkg::PH_HOST_ON;
            end
            else if (t < t_pc)
            begin
                phase_next  = pcbst_pkg::PH_CAM_WAIT;
                pcount_next = PCOUNT_W'(t - t_p);
            end
            else if (t == t_pc)
            begin
                phase_next  = pcbst_pkg::PH_CAM_ON;
                pcount_next = PCOUNT_W'(t - t_p);
            end
            else if (t <= t_pd)
            begin
                phase_next  = pcbst_pkg::PH_CHECK_WAIT;
                pcount_next = PCOUNT_W'(t - t_p);
            end
            else if (t <= t_pk)
            begin
                phase_next  = pcbst_pkg::PH_CHECKING;
                pcount_next = PCOUNT_W'(t - t_pd);
            end
            else
            begin
                phase_next = pcbst_pkg::PH_DONE;
                pos_next   = '0;
            end

            case (phase_next)
                pcbst_pkg::PH_OFF:
                begin
                    send_next = 1'b1;
                    pin       = pcbst_pkg::off_pins(polarity_reg);
                    win_next  = '0;
                end
                pcbst_pkg::PH_HOST_ON:
                begin
                    send_next = 1'b1;
                    pin       = pcbst_pkg::host_pins(polarity_reg);
                end
                pcbst_pkg::PH_CAM_ON:
                begin
                    send_next = 1'b1;
                    pin       = pcbst_pkg::cam_pins(polarity_reg);
                end
                pcbst_pkg::PH_CHECKING:
                begin
                    regions_next = blank_count;
                    if (blank_count != '0 && win_base != '1)
                    begin
                        win_next = win_base + WIN_W'(1);
                    end
                end
                pcbst_pkg::PH_DONE:
                begin
                    if (done_base != '1)
                    begin
                        done_next = done_base + TEST_W'(1);
                    end
                    // Every window blank (or no windows at all) fails the cycle
                    if (win_base == check_ticks_reg)
                    begin
                        failed_next = 1'b1;
                        if (fail_base != '1)
                        begin
                            fail_next = fail_base + TEST_W'(1);
                        end
                    end
                end
                default: ;
            endcase

            stopped_next = stop_on_blank_reg && (fail_next != '0);
        end

        pin_next   = pin;
        cksum_next = send_next ? (pcbst_pkg::FRAME_HDR_XOR ^ pin) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= pcbst_pkg::PH_IDLE;
            pcount_reg  <= '0;
            send_reg    <= 1'b0;
            pin_reg     <= '0;
            cksum_reg   <= '0;
            regions_reg <= '0;
            win_reg     <= '0;
            done_reg    <= '0;
            fail_reg    <= '0;
            failed_reg  <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else if (adv)
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            pcount_reg  <= pcount_next;
            send_reg    <= send_next;
            pin_reg     <= pin_next;
            cksum_reg   <= cksum_next;
            regions_reg <= regions_next;
            win_reg     <= win_next;
            done_reg    <= done_next;
            fail_reg    <= fail_next;
            failed_reg  <= failed_next;
            stopped_reg <= stopped_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result stream
    // ---------------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, stopped_reg, failed_reg, fail_reg, done_reg, win_reg,
                            regions_reg, cksum_reg, pin_reg, send_reg, pcount_reg,
                            phase_reg};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_fail_le_done: assert property (@(posedge clk) disable iff (!rst_n)
        fail_reg <= done_reg)
        else $error("failure count ran ahead of test count");

    a_frame_on_power_step: assert property (@(posedge clk) disable iff (!rst_n)
        send_reg |-> (phase_reg == pcbst_pkg::PH_OFF || phase_reg == pcbst_pkg::PH_HOST_ON
                      || phase_reg == pcbst_pkg::PH_CAM_ON))
        else $error("frame sent outside a power step");

    a_failed_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (phase_reg == pcbst_pkg::PH_DONE && fail_reg != '0))
        else $error("failed cycle flagged outside the done tick");

    a_frozen_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && frozen && !restart) |=> ($stable(pos_reg) && $stable(done_reg)))
        else $error("sequence advanced while stopped");

endmodule
